### rtl/core/mck_pkg.sv
`timescale 1ns / 1ps

package mck_pkg;

  // Sizing
  localparam int unsigned MaxSymbols = 6;
  localparam int unsigned PatW       = 6;
  localparam int unsigned PatSelW    = $clog2(PatW);
  localparam int unsigned LenW       = 3;
  localparam int unsigned IdxW       = $clog2(MaxSymbols + 1);
  localparam int unsigned CodeW      = 8;
  localparam int unsigned KindW      = 3;
  localparam int unsigned HzW        = 12;
  localparam int unsigned DurW       = 11;
  localparam int unsigned DotW       = 10;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 12;
  localparam int unsigned NumCfg     = 5;
  localparam int unsigned CfgAddrW   = $clog2(NumCfg);

  // Register indexes
  localparam logic [CfgIdxW-1:0] CfgToneHz    = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgDotMs     = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgDashMs    = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgPauseMs   = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgLetterGap = 3'd4;

  // Register reset values
  localparam logic [CfgDataW-1:0] RstToneHz    = 12'd400;
  localparam logic [CfgDataW-1:0] RstDotMs     = 12'd100;
  localparam logic [CfgDataW-1:0] RstDashMs    = 12'd200;
  localparam logic [CfgDataW-1:0] RstPauseMs   = 12'd500;
  localparam logic [CfgDataW-1:0] RstLetterGap = 12'd170;

  localparam logic [CodeW-1:0] CharSpace = 8'h20;

  typedef enum logic [KindW-1:0] {
    KindDot     = 3'd0,
    KindDash    = 3'd1,
    KindWord    = 3'd2,
    KindUnknown = 3'd3,
    KindLetter  = 3'd4
  } kind_e;

  // Character class: keyed pattern, space or anything else
  typedef enum logic [1:0] {
    ClsSym,
    ClsWord,
    ClsUnknown
  } cls_e;

  // Pattern: symbol count and symbols left-aligned, first symbol in the MSB,
  // 1 = dash, 0 = dot. Count of zero means no pattern.
  typedef struct packed {
    logic [LenW-1:0] len;
    logic [PatW-1:0] sym;
  } pat_t;

  function automatic pat_t pat_lookup(input logic [CodeW-1:0] code);
    pat_t p;
    case (code)
      8'h41: p = '{3'd2, 6'b010000}; // A
      8'h42: p = '{3'd4, 6'b100000}; // B
      8'h43: p = '{3'd4, 6'b101000}; // C
      8'h44: p = '{3'd3, 6'b100000}; // D
      8'h45: p = '{3'd1, 6'b000000}; // E
      8'h46: p = '{3'd4, 6'b001000}; // F
      8'h47: p = '{3'd3, 6'b110000}; // G
      8'h48: p = '{3'd4, 6'b000000}; // H
      8'h49: p = '{3'd2, 6'b000000}; // I
      8'h4A: p = '{3'd4, 6'b011100}; // J
      8'h4B: p = '{3'd3, 6'b101000}; // K
      8'h4C: p = '{3'd4, 6'b010000}; // L
      8'h4D: p = '{3'd2, 6'b110000}; // M
      8'h4E: p = '{3'd2, 6'b100000}; // N
      8'h4F: p = '{3'd3, 6'b111000}; // O
      8'h50: p = '{3'd4, 6'b011000}; // P
      8'h51: p = '{3'd4, 6'b110100}; // Q
      8'h52: p = '{3'd3, 6'b010000}; // R
      8'h53: p = '{3'd3, 6'b000000}; // S
      8'h54: p = '{3'd1, 6'b100000}; // T
      8'h55: p = '{3'd3, 6'b001000}; // U
      8'h56: p = '{3'd4, 6'b000100}; // V
      8'h57: p = '{3'd3, 6'b011000}; // W
      8'h58: p = '{3'd4, 6'b100100}; // X
      8'h59: p = '{3'd4, 6'b101100}; // Y
      8'h5A: p = '{3'd4, 6'b110000}; // Z
      8'h31: p = '{3'd5, 6'b011110}; // 1
      8'h32: p = '{3'd5, 6'b001110}; // 2
      8'h33: p = '{3'd5, 6'b000110}; // 3
      8'h34: p = '{3'd5, 6'b000010}; // 4
      8'h35: p = '{3'd5, 6'b000000}; // 5
      8'h36: p = '{3'd5, 6'b100000}; // 6
      8'h37: p = '{3'd5, 6'b110000}; // 7
      8'h38: p = '{3'd5, 6'b111000}; // 8
      8'h39: p = '{3'd5, 6'b111100}; // 9
      8'h30: p = '{3'd5, 6'b111110}; // 0
      8'h2E: p = '{3'd6, 6'b010101}; // period
      8'h2C: p = '{3'd6, 6'b110011}; // comma
      8'h3F: p = '{3'd6, 6'b001100}; // question mark
      8'h2F: p = '{3'd5, 6'b100100}; // slash
      8'h40: p = '{3'd6, 6'b011010}; // at sign
      8'h21: p = '{3'd6, 6'b101011}; // exclamation
      8'h3A: p = '{3'd6, 6'b111000}; // colon
      8'h3B: p = '{3'd6, 6'b101010}; // semicolon
      8'h27: p = '{3'd6, 6'b011110}; // apostrophe
      8'h3D: p = '{3'd5, 6'b100010}; // equals
      default: p = '{3'd0, 6'b000000};
    endcase
    return p;
  endfunction

  // Value of a register slot that was never written
  function automatic logic [CfgDataW-1:0] cfg_reset(input logic [CfgAddrW-1:0] addr);
    logic [CfgDataW-1:0] v;
    case (CfgIdxW'(addr))
      CfgToneHz:    v = RstToneHz;
      CfgDotMs:     v = RstDotMs;
      CfgDashMs:    v = RstDashMs;
      CfgPauseMs:   v = RstPauseMs;
      CfgLetterGap: v = RstLetterGap;
      default:      v = '0;
    endcase
    return v;
  endfunction

  // Trim write data to the width of the addressed register
  function automatic logic [CfgDataW-1:0] cfg_mask(input logic [CfgIdxW-1:0] idx,
                                                  input logic [CfgDataW-1:0] data);
    logic [CfgDataW-1:0] v;
    case (idx)
      CfgToneHz: v = data;
      CfgDotMs:  v = CfgDataW'(data[DotW-1:0]);
      default:   v = CfgDataW'(data[DurW-1:0]);
    endcase
    return v;
  endfunction

  // Register slot holding the duration of an element kind
  function automatic logic [CfgAddrW-1:0] dur_addr(input kind_e kind);
    logic [CfgIdxW-1:0] idx;
    case (kind)
      KindDot:     idx = CfgDotMs;
      KindDash:    idx = CfgDashMs;
      KindWord:    idx = CfgPauseMs;
      KindUnknown: idx = CfgPauseMs;
      default:     idx = CfgLetterGap;
    endcase
    return CfgAddrW'(idx);
  endfunction

endpackage

### rtl/core/mck_if.sv
`timescale 1ns / 1ps

// Character input channel
interface mck_char_if import mck_pkg::*;;
  logic             valid;
  logic             ready;
  logic [CodeW-1:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink (input valid, input char_code, output ready);
endinterface

// Register write channel
interface mck_cfg_if import mck_pkg::*;;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// Keyed element output channel
interface mck_elem_if import mck_pkg::*;;
  logic             valid;
  logic             ready;
  logic [KindW-1:0] element_kind;
  logic             tone_on;
  logic [HzW-1:0]   tone_hz;
  logic [DurW-1:0]  duration_ms;
  logic             last_element;

  modport source (output valid, output element_kind, output tone_on, output tone_hz,
                  output duration_ms, output last_element, input ready);
  modport sink (input valid, input element_kind, input tone_on, input tone_hz,
                input duration_ms, input last_element, output ready);
endinterface

### rtl/core/mck_ram.sv
`timescale 1ns / 1ps

// Simple dual-port RAM, one write port, one read port, registered read data
module mck_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 8,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### rtl/core/morse_character_keyer_unit.sv
`timescale 1ns / 1ps

// Morse character keyer. Each character item on char_i is keyed as a run of
// element items on elem_o: one per dot or dash of its International Morse
// pattern (upper-case letters, digits and . , ? / @ ! : ; ' =), one word gap
// for a space, or one unknown pause for any other code, always followed by a
// silent letter gap flagged last_element. Tone elements carry the configured
// frequency, silent ones carry tone_hz of 0. The five timing/tone registers
// live in a small synchronous RAM and are read back for every element: a
// tone element steps through a frequency read, a duration read, an output
// load and a handoff that waits for elem_o.ready, a silent one skips the
// frequency read, and each character is first taken in the idle state. A
// character is keyed as at most six tone elements and the letter gap. One
// character is keyed at a time; the next is taken after the letter gap has
// been delivered. Registers are to be written through cfg_i only while the
// keyer is idle; the keyer itself does not enforce this. Indexes above four
// are ignored. Unwritten registers read as their reset values.
module morse_character_keyer_unit import mck_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  mck_char_if.sink       char_i,
  mck_cfg_if.sink        cfg_i,
  mck_elem_if.source     elem_o
);

  typedef enum logic [2:0] {
    StIdle,
    StKind,
    StHz,
    StDur,
    StOut
  } state_e;

  state_e               state_q;
  cls_e                 cls_q;
  logic [PatW-1:0]      sym_q;
  logic [IdxW-1:0]      cnt_q;
  logic [IdxW-1:0]      idx_q;
  kind_e                kind_q;
  logic                 last_q;
  logic [HzW-1:0]       hz_q;
  logic [CfgAddrW-1:0]  raddr_q;
  logic [NumCfg-1:0]    cfg_valid_q;

  logic                 out_valid_q;
  logic [KindW-1:0]     out_kind_q;
  logic                 out_tone_q;
  logic [HzW-1:0]       out_hz_q;
  logic [DurW-1:0]      out_dur_q;
  logic                 out_last_q;

  logic                 cfg_we;
  logic [CfgAddrW-1:0]  raddr;
  logic [CfgDataW-1:0]  rdata;
  logic [CfgDataW-1:0]  cfg_val;
  kind_e                kind_d;
  logic                 last_d;
  logic [PatSelW-1:0]   sym_sel;
  pat_t                 pat;
  logic [IdxW-1:0]      pat_cnt;

  // Register writes: in-range indexes only
  assign cfg_i.ready = 1'b1;
  assign cfg_we      = cfg_i.valid && (cfg_i.index < CfgIdxW'(NumCfg));

  mck_ram #(
    .Width (CfgDataW),
    .Depth (NumCfg)
  ) u_cfg_ram (
    .clk_i   (clk_i),
    .we_i    (cfg_we),
    .waddr_i (CfgAddrW'(cfg_i.index)),
    .wdata_i (cfg_mask(cfg_i.index, cfg_i.data)),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Unwritten slots fall back to their reset values
  assign cfg_val = cfg_valid_q[raddr_q] ? rdata : cfg_reset(raddr_q);

  // Pattern lookup, trimmed to the symbol limit
  assign pat     = pat_lookup(char_i.char_code);
  assign pat_cnt = (IdxW'(pat.len) > IdxW'(MaxSymbols)) ? IdxW'(MaxSymbols)
                                                         : IdxW'(pat.len);

  // Next element of the current character
  assign sym_sel = PatSelW'(PatW - 1) - idx_q[PatSelW-1:0];

  always_comb begin
    kind_d = KindLetter;
    last_d = 1'b1;
    if ((cls_q == ClsSym) && (idx_q < cnt_q)) begin
      kind_d = sym_q[sym_sel] ? KindDash : KindDot;
      last_d = 1'b0;
    end else if ((cls_q != ClsSym) && (idx_q == '0)) begin
      kind_d = (cls_q == ClsWord) ? KindWord : KindUnknown;
      last_d = 1'b0;
    end
  end

  // RAM read address per state
  always_comb begin
    case (state_q)
      StKind: begin
        raddr = ((kind_d == KindDot) || (kind_d == KindDash)) ? CfgAddrW'(CfgToneHz)
                                                              : dur_addr(kind_d);
      end
      StHz:    raddr = dur_addr(kind_q);
      default: raddr = raddr_q;
    endcase
  end

  assign char_i.ready        = (state_q == StIdle);
  assign elem_o.valid        = out_valid_q;
  assign elem_o.element_kind = out_kind_q;
  assign elem_o.tone_on      = out_tone_q;
  assign elem_o.tone_hz      = out_hz_q;
  assign elem_o.duration_ms  = out_dur_q;
  assign elem_o.last_element = out_last_q;

  // Sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cfg_valid_q <= '0;
      out_valid_q <= 1'b0;
      raddr_q     <= '0;
    end else begin
      raddr_q <= raddr;
      if (cfg_we) begin
        cfg_valid_q[CfgAddrW'(cfg_i.index)] <= 1'b1;
      end
      case (state_q)
        StIdle: begin
          if (char_i.valid) begin
            idx_q <= '0;
            sym_q <= pat.sym;
            cnt_q <= pat_cnt;
            if (char_i.char_code == CharSpace) begin
              cls_q <= ClsWord;
            end else if (pat.len == '0) begin
              cls_q <= ClsUnknown;
            end else begin
              cls_q <= ClsSym;
            end
            state_q <= StKind;
          end
        end
        StKind: begin
          kind_q <= kind_d;
          last_q <= last_d;
          if ((kind_d == KindDot) || (kind_d == KindDash)) begin
            state_q <= StHz;
          end else begin
            hz_q    <= '0;
            state_q <= StDur;
          end
        end
        StHz: begin
          hz_q    <= cfg_val;
          state_q <= StDur;
        end
        StDur: begin
          out_valid_q <= 1'b1;
          out_kind_q  <= kind_q;
          out_tone_q  <= (kind_q == KindDot) || (kind_q == KindDash);
          out_hz_q    <= hz_q;
          out_dur_q   <= cfg_val[DurW-1:0];
          out_last_q  <= last_q;
          state_q     <= StOut;
        end
        StOut: begin
          if (elem_o.ready) begin
            out_valid_q <= 1'b0;
            idx_q       <= idx_q + 1'b1;
            state_q     <= out_last_q ? StIdle : StKind;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule
